// ===== rtl/core/lcdns_pkg.sv =====
package lcdns_pkg;

   localparam int unsigned POWER_ON_WAIT_US = 50000;

   localparam int unsigned FIFO_DEPTH = 2;
   localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam int unsigned STEP_IDX_W = 6;

   typedef enum logic [1:0] {
      FUNC_INIT = 2'd0,
      FUNC_CMD  = 2'd1,
      FUNC_DATA = 2'd2,
      FUNC_TEXT = 2'd3
   } func_type;

   localparam logic [7:0] CHAR_NEWLINE    = 8'd10;
   localparam logic [7:0] CHAR_FIRST_PRINT = 8'd32;
   localparam logic [7:0] CHAR_LAST_PRINT = 8'd126;
   localparam logic [7:0] CMD_LINE_TWO    = 8'hC0;

   localparam logic [7:0] CMD_FUNC_SET    = 8'h28;
   localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0C;
   localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
   localparam logic [7:0] CMD_CLEAR       = 8'h01;

   localparam logic [3:0] NIB_WAKE        = 4'h3;
   localparam logic [3:0] NIB_FOUR_BIT    = 4'h2;

   localparam logic [15:0] WAIT_POWER_ON  = 16'(POWER_ON_WAIT_US);
   localparam logic [15:0] WAIT_WAKE      = 16'd5000;
   localparam logic [15:0] WAIT_SHORT     = 16'd2500;
   localparam logic [15:0] WAIT_SETTLE    = 16'd100;
   localparam logic [15:0] WAIT_PULSE     = 16'd1;

   localparam logic RS_CMD  = 1'b0;
   localparam logic RS_DATA = 1'b1;

   typedef enum logic {
      OP_INIT,
      OP_BYTE
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic        rs;
      logic [7:0]  data;
   } op_type;

   typedef struct packed {
      logic        set_rs;
      logic        rs;
      logic        set_nib;
      logic [3:0]  nib;
      logic        enable;
      logic [15:0] wait_us;
      logic        last;
   } step_type;

   typedef struct packed {
      logic        reg_select;
      logic [3:0]  nibble;
      logic        enable;
      logic [15:0] wait_us;
      logic        last;
   } pins_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } back_state_type;

   // One step of a byte transfer: two enable pulses, then a settle hold.
   function automatic step_type byte_step(input logic [2:0] pos, input logic rs,
                                          input logic [7:0] data, input logic is_end);
      step_type s;
      s.set_rs  = (pos == 3'd0);
      s.rs      = rs;
      s.set_nib = (pos == 3'd0) || (pos == 3'd2);
      s.nib     = (pos == 3'd0) ? data[7:4] : data[3:0];
      s.enable  = (pos == 3'd0) || (pos == 3'd2);
      s.wait_us = (pos == 3'd4) ? WAIT_SETTLE : WAIT_PULSE;
      s.last    = is_end && (pos == 3'd4);
      return s;
   endfunction

   function automatic step_type hold_step(input logic [15:0] wait_us, input logic last);
      step_type s;
      s.set_rs  = 1'b0;
      s.rs      = RS_CMD;
      s.set_nib = 1'b0;
      s.nib     = 4'h0;
      s.enable  = 1'b0;
      s.wait_us = wait_us;
      s.last    = last;
      return s;
   endfunction

   // Nibble pulse that keeps the current register-select level.
   function automatic step_type pulse_step(input logic [3:0] nib, input logic high);
      step_type s;
      s.set_rs  = 1'b0;
      s.rs      = RS_CMD;
      s.set_nib = high;
      s.nib     = nib;
      s.enable  = high;
      s.wait_us = WAIT_PULSE;
      s.last    = 1'b0;
      return s;
   endfunction

   function automatic step_type init_step(input logic [STEP_IDX_W-1:0] idx);
      step_type s;
      unique case (idx)
         6'd0:  s = hold_step(WAIT_POWER_ON, 1'b0);
         6'd1:  s = pulse_step(NIB_WAKE, 1'b1);
         6'd2:  s = pulse_step(NIB_WAKE, 1'b0);
         6'd3:  s = hold_step(WAIT_WAKE, 1'b0);
         6'd4:  s = pulse_step(NIB_WAKE, 1'b1);
         6'd5:  s = pulse_step(NIB_WAKE, 1'b0);
         6'd6:  s = hold_step(WAIT_WAKE, 1'b0);
         6'd7:  s = pulse_step(NIB_WAKE, 1'b1);
         6'd8:  s = pulse_step(NIB_WAKE, 1'b0);
         6'd9:  s = hold_step(WAIT_WAKE, 1'b0);
         6'd10: s = pulse_step(NIB_FOUR_BIT, 1'b1);
         6'd11: s = pulse_step(NIB_FOUR_BIT, 1'b0);
         6'd12: s = hold_step(WAIT_SHORT, 1'b0);
         6'd13: s = byte_step(3'd0, RS_CMD, CMD_FUNC_SET, 1'b0);
         6'd14: s = byte_step(3'd1, RS_CMD, CMD_FUNC_SET, 1'b0);
         6'd15: s = byte_step(3'd2, RS_CMD, CMD_FUNC_SET, 1'b0);
         6'd16: s = byte_step(3'd3, RS_CMD, CMD_FUNC_SET, 1'b0);
         6'd17: s = byte_step(3'd4, RS_CMD, CMD_FUNC_SET, 1'b0);
         6'd18: s = byte_step(3'd0, RS_CMD, CMD_DISPLAY_ON, 1'b0);
         6'd19: s = byte_step(3'd1, RS_CMD, CMD_DISPLAY_ON, 1'b0);
         6'd20: s = byte_step(3'd2, RS_CMD, CMD_DISPLAY_ON, 1'b0);
         6'd21: s = byte_step(3'd3, RS_CMD, CMD_DISPLAY_ON, 1'b0);
         6'd22: s = byte_step(3'd4, RS_CMD, CMD_DISPLAY_ON, 1'b0);
         6'd23: s = byte_step(3'd0, RS_CMD, CMD_ENTRY_MODE, 1'b0);
         6'd24: s = byte_step(3'd1, RS_CMD, CMD_ENTRY_MODE, 1'b0);
         6'd25: s = byte_step(3'd2, RS_CMD, CMD_ENTRY_MODE, 1'b0);
         6'd26: s = byte_step(3'd3, RS_CMD, CMD_ENTRY_MODE, 1'b0);
         6'd27: s = byte_step(3'd4, RS_CMD, CMD_ENTRY_MODE, 1'b0);
         6'd28: s = byte_step(3'd0, RS_CMD, CMD_CLEAR, 1'b0);
         6'd29: s = byte_step(3'd1, RS_CMD, CMD_CLEAR, 1'b0);
         6'd30: s = byte_step(3'd2, RS_CMD, CMD_CLEAR, 1'b0);
         6'd31: s = byte_step(3'd3, RS_CMD, CMD_CLEAR, 1'b0);
         6'd32: s = byte_step(3'd4, RS_CMD, CMD_CLEAR, 1'b0);
         default: s = hold_step(WAIT_SHORT, 1'b1);
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/core/lcdns_if.sv =====
interface lcdns_req_if;
   import lcdns_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] value;

   modport source (output valid, output func, output value, input ready);
   modport sink (input valid, input func, input value, output ready);
endinterface

interface lcdns_rsp_if;
   import lcdns_pkg::*;
   logic        valid;
   logic        ready;
   logic        reg_select;
   logic [3:0]  nibble;
   logic        enable;
   logic [15:0] wait_us;
   logic        last;

   modport source (output valid, output reg_select, output nibble, output enable,
                   output wait_us, output last, input ready);
   modport sink (input valid, input reg_select, input nibble, input enable,
                 input wait_us, input last, output ready);
endinterface

// ===== rtl/core/lcdns_front.sv =====
module lcdns_front
   import lcdns_pkg::*;
(
   lcdns_req_if.sink req_ch,
   input  logic      fifo_full,
   output logic      op_push,
   output op_type    op_word
);

   logic keep;

   assign req_ch.ready = !fifo_full;

   always_comb begin
      keep         = 1'b1;
      op_word.kind = OP_BYTE;
      op_word.rs   = RS_CMD;
      op_word.data = req_ch.value;
      unique case (func_type'(req_ch.func))
         FUNC_INIT: begin
            op_word.kind = OP_INIT;
         end
         FUNC_CMD: begin
            op_word.rs = RS_CMD;
         end
         FUNC_DATA: begin
            op_word.rs = RS_DATA;
         end
         FUNC_TEXT: begin
            // newline moves to the second line, printables go out as data, drop the rest
            if (req_ch.value == CHAR_NEWLINE) begin
               op_word.data = CMD_LINE_TWO;
            end else if (req_ch.value >= CHAR_FIRST_PRINT &&
                         req_ch.value <= CHAR_LAST_PRINT) begin
               op_word.rs = RS_DATA;
            end else begin
               keep = 1'b0;
            end
         end
         default: keep = 1'b0;
      endcase
   end

   assign op_push = req_ch.valid && !fifo_full && keep;

endmodule

// ===== rtl/core/lcdns_fifo.sv =====
module lcdns_fifo
   import lcdns_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_word,
   output logic   full,
   input  logic   pop,
   output op_type pop_word,
   output logic   empty
);

   op_type                mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_word = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ===== rtl/core/lcdns_back.sv =====
module lcdns_back
   import lcdns_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      fifo_empty,
   input  op_type    fifo_word,
   output logic      fifo_pop,
   lcdns_rsp_if.source rsp_ch
);

   back_state_type        state_ff, state_in;
   op_type                op_ff, op_in;
   logic [STEP_IDX_W-1:0] idx_ff, idx_in;
   logic                  rs_ff, rs_in;
   logic [3:0]            nib_ff, nib_in;
   pins_type              out_ff, out_in;
   logic                  out_valid_ff, out_valid_in;
   step_type              step;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      rs_in        = rs_ff;
      nib_in       = nib_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      fifo_pop     = 1'b0;

      if (op_ff.kind == OP_BYTE) begin
         step = byte_step(idx_ff[2:0], op_ff.rs, op_ff.data, 1'b1);
      end else begin
         step = init_step(idx_ff);
      end

      if (out_valid_ff && rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (!fifo_empty) begin
               fifo_pop = 1'b1;
               op_in    = fifo_word;
               idx_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            // advance only when the output register is free or being drained
            if (!out_valid_ff || rsp_ch.ready) begin
               if (step.set_rs) begin
                  rs_in = step.rs;
               end
               if (step.set_nib) begin
                  nib_in = step.nib;
               end
               out_in.reg_select = step.set_rs ? step.rs : rs_ff;
               out_in.nibble     = step.set_nib ? step.nib : nib_ff;
               out_in.enable     = step.enable;
               out_in.wait_us    = step.wait_us;
               out_in.last       = step.last;
               out_valid_in      = 1'b1;
               idx_in            = idx_ff + 1'b1;
               if (step.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rs_ff        <= 1'b0;
         nib_ff       <= 4'h0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rs_ff        <= rs_in;
         nib_ff       <= nib_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      idx_ff <= idx_in;
      out_ff <= out_in;
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.reg_select = out_ff.reg_select;
   assign rsp_ch.nibble     = out_ff.nibble;
   assign rsp_ch.enable     = out_ff.enable;
   assign rsp_ch.wait_us    = out_ff.wait_us;
   assign rsp_ch.last       = out_ff.last;

endmodule

// ===== rtl/core/char_lcd_nibble_sequencer.sv =====
// Character LCD sequencer for a 4-bit parallel display bus.
// req_ch carries one operation per word: func selects initialise, command
// byte, data byte or text character, value holds the byte or character.
// rsp_ch carries one pin step per word: register-select level, D4..D7
// levels, enable level and a hold time in microseconds; last marks the
// final step of an operation. Text characters outside newline and the
// printable range are accepted and produce no steps.
// A front stage classifies each word into a two-entry queue; the back
// stage pops one operation and emits its steps from a registered output.
// The first step passes through the queue, the back stage's operation
// register and the output register. Throughput: one step per cycle while
// rsp_ch is ready, and each operation passes through the idle state to pop
// the queue before its steps. req_ch stalls only when the queue is full.
// When rsp_ch stalls, the output word holds and the sequencer waits.
// Synchronous reset clears the queue, the output valid and the pin
// levels (register select and data low).
module char_lcd_nibble_sequencer
   import lcdns_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   lcdns_req_if.sink   req_ch,
   lcdns_rsp_if.source rsp_ch
);

   logic   op_push;
   op_type op_word;
   logic   fifo_full;
   logic   fifo_pop;
   op_type fifo_word;
   logic   fifo_empty;

   lcdns_front u_front (
      .req_ch    (req_ch),
      .fifo_full (fifo_full),
      .op_push   (op_push),
      .op_word   (op_word)
   );

   lcdns_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_word (op_word),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .pop_word  (fifo_word),
      .empty     (fifo_empty)
   );

   lcdns_back u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .fifo_word  (fifo_word),
      .fifo_pop   (fifo_pop),
      .rsp_ch     (rsp_ch)
   );

endmodule
